/* hw/rtl/ars_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_pkg
// Shared widths, constants and the job record passed from front to back.
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam int ADDR_W          = 64;
  localparam int SIZE_W          = 33;
  localparam int MAX_PARTS       = 64;
  localparam int CNT_W           = $clog2(MAX_PARTS + 1);
  localparam int DIV_CNT_W       = $clog2(ADDR_W);
  localparam int QUEUE_DEPTH     = 2;  // power of two
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SIZE_W-1:0] SEG_SIZE_RESET = SIZE_W'(64'd8388608);

  // One split job: aligned start, end of span, part size, offset into first part
  typedef struct packed {
    logic [ADDR_W-1:0] aligned;
    logic [ADDR_W-1:0] held;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] rem;
  } job_t;

endpackage

/* hw/rtl/ars_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_front
// Accepts requests, drops empty ones, finds the alignment remainder with a
// bit-serial restoring divider and pushes a job into the queue.
// ----------------------------------------------------------------------------
module ars_front
  import ars_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ADDR_W-1:0] region_offset,
  input  logic [ADDR_W-1:0] held_start,
  input  logic [SIZE_W-1:0] seg_size,
  output logic              push,
  output job_t              push_job,
  input  logic              q_full
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t              state;
  logic [ADDR_W-1:0]    region;
  logic [ADDR_W-1:0]    held;
  logic [ADDR_W-1:0]    dividend;
  logic [SIZE_W-1:0]    size;
  logic [SIZE_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [SIZE_W:0]   rem_sh;
  logic              rem_ge;
  logic [SIZE_W-1:0] rem_next;
  logic              accept;

  assign in_stall = (state != F_IDLE);
  assign accept   = in_valid && !in_stall;

  // one quotient bit per cycle; remainder stays below size
  assign rem_sh   = {rem, dividend[ADDR_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, size});
  assign rem_next = rem_ge ? SIZE_W'(rem_sh - {1'b0, size}) : rem_sh[SIZE_W-1:0];

  assign push             = (state == F_PUSH) && !q_full;
  assign push_job.aligned = region - {{(ADDR_W-SIZE_W){1'b0}}, rem};
  assign push_job.held    = held;
  assign push_job.size    = size;
  assign push_job.rem     = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && (region_offset < held_start)) begin
            region   <= region_offset;
            held     <= held_start;
            dividend <= region_offset;
            size     <= (seg_size == '0) ? SIZE_W'(1) : seg_size;
            rem      <= '0;
            div_cnt  <= '0;
            state    <= F_DIV;
          end
        end
        F_DIV: begin
          rem      <= rem_next;
          dividend <= {dividend[ADDR_W-2:0], 1'b0};
          div_cnt  <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(ADDR_W - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/ars_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_queue
// Short register queue of jobs between front and back.
// ----------------------------------------------------------------------------
module ars_queue
  import ars_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/ars_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_back
// Walks a job part by part and drives the registered result channel.
// ----------------------------------------------------------------------------
module ars_back
  import ars_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  job_t              q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] seg_start,
  output logic [ADDR_W-1:0] seg_end,
  output logic              has_leading_bytes,
  output logic [SIZE_W-1:0] leading_bytes,
  output logic              last_part,
  output logic              truncated
);

  typedef enum logic [1:0] {B_IDLE, B_LOAD, B_EMIT} bstate_t;

  bstate_t           state;
  job_t              job;
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] remain;
  logic [ADDR_W-1:0] held_m1;
  logic [ADDR_W-1:0] size_m1;
  logic [CNT_W-1:0]  cnt;

  logic              slot_free;
  logic              emit;
  logic              is_final;
  logic              is_cut;
  logic [ADDR_W-1:0] size_x;

  assign size_x    = {{(ADDR_W-SIZE_W){1'b0}}, job.size};
  assign slot_free = !out_valid || !out_stall;
  assign emit      = (state == B_EMIT) && slot_free;
  assign is_final  = (remain <= size_x);
  assign is_cut    = !is_final && (cnt == CNT_W'(MAX_PARTS - 1));
  assign pop       = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            job   <= q_head;
            state <= B_LOAD;
          end
        end
        B_LOAD: begin
          cursor  <= job.aligned;
          remain  <= job.held - job.aligned;
          held_m1 <= job.held - ADDR_W'(1);
          size_m1 <= size_x - ADDR_W'(1);
          cnt     <= '0;
          state   <= B_EMIT;
        end
        B_EMIT: begin
          if (emit) begin
            seg_start         <= cursor;
            seg_end           <= is_final ? held_m1 : cursor + size_m1;
            // only the first part can start before the region
            has_leading_bytes <= (cnt == '0) && (job.rem != '0);
            leading_bytes     <= (cnt == '0) ? job.rem : '0;
            last_part         <= is_final || is_cut;
            truncated         <= is_cut;
            cursor            <= cursor + size_x;
            remain            <= remain - size_x;
            cnt               <= cnt + CNT_W'(1);
            if (is_final || is_cut) begin
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/aligned_range_splitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_range_splitter
// Splits the span from region_offset up to held_start into aligned parts.
// ----------------------------------------------------------------------------
// Each request item names a region start and the first byte already held.
// A request with region_offset >= held_start is accepted and gives no
// results. Otherwise the front accepts the request, computes the bit-serial
// remainder of region_offset by seg_size (one bit a cycle), then hands the
// job to a two-entry queue when it is not full. The back then takes the
// job, loads it and emits one part per cycle while the output is not
// stalled; front and back overlap, so the sustained rate is set by the
// slower of the divider and the part walk. Up to MAX_PARTS (64) parts are
// emitted; if more span remains, the final item carries last_part and
// truncated. A seg_size of zero acts as one. The user must write seg_size
// through the cfg port only while the block is idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module aligned_range_splitter
  import ars_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  // request items
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ADDR_W-1:0] region_offset,
  input  logic [ADDR_W-1:0] held_start,
  // result items
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] seg_start,
  output logic [ADDR_W-1:0] seg_end,
  output logic              has_leading_bytes,
  output logic [SIZE_W-1:0] leading_bytes,
  output logic              last_part,
  output logic              truncated
);

  logic [SIZE_W-1:0] seg_size;
  logic              push;
  job_t              push_job;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  job_t              q_head;

  // the register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size <= SEG_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seg_size <= cfg_data;
    end
  end

  // front: accept, filter empty requests, divide for the alignment remainder
  ars_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .region_offset (region_offset),
    .held_start    (held_start),
    .seg_size      (seg_size),
    .push          (push),
    .push_job      (push_job),
    .q_full        (q_full)
  );

  // decoupling queue so the divider can start the next item while parts flow
  ars_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // back: one part per cycle into the output register while the output is not stalled
  ars_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .seg_start         (seg_start),
    .seg_end           (seg_end),
    .has_leading_bytes (has_leading_bytes),
    .leading_bytes     (leading_bytes),
    .last_part         (last_part),
    .truncated         (truncated)
  );

endmodule

/* hw/rtl/ars_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_checker
// Port-level checks on the result channel of aligned_range_splitter.
// ----------------------------------------------------------------------------
module ars_checker
  import ars_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ADDR_W-1:0] seg_start,
  input logic [ADDR_W-1:0] seg_end,
  input logic              has_leading_bytes,
  input logic [SIZE_W-1:0] leading_bytes,
  input logic              last_part,
  input logic              truncated
);

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated) |-> last_part)
    else $error("truncated without last_part");

  a_end_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (seg_end >= seg_start))
    else $error("seg_end below seg_start");

  a_lead_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_leading_bytes) |-> (leading_bytes == '0))
    else $error("leading bytes without flag");

  a_lead_set: assert property (@(posedge clk) disable iff (rst)
    (out_valid && has_leading_bytes) |-> (leading_bytes != '0))
    else $error("flag without leading bytes");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(seg_start)))
    else $error("stalled item changed");

endmodule

bind aligned_range_splitter ars_checker u_ars_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .seg_start         (seg_start),
  .seg_end           (seg_end),
  .has_leading_bytes (has_leading_bytes),
  .leading_bytes     (leading_bytes),
  .last_part         (last_part),
  .truncated         (truncated)
);
